@@ design/psc_pkg.sv @@
package psc_pkg;
  localparam int CW = 16;
  localparam int TOL_SHIFT = 20;
  localparam int VW = 36;
  localparam int QW = 17;
  localparam int NDIV = 17;
  localparam int RW = 37;

  localparam logic [1:0] ST_OUT = 2'd0;
  localparam logic [1:0] ST_SAME = 2'd1;
  localparam logic [1:0] ST_CROSS_NEG = 2'd2;
  localparam logic [1:0] ST_CROSS = 2'd3;

  localparam logic [1:0] REG_A = 2'd0;
  localparam logic [1:0] REG_B = 2'd1;
  localparam logic [1:0] REG_C = 2'd2;
  localparam logic [1:0] REG_D = 2'd3;

  typedef struct packed {
    logic              vld;
    logic              go;
    logic [1:0]        status;
    logic              neg2;
    logic signed [CW-1:0] p1x, p1y, p1z;
    logic signed [CW:0]   vx, vy, vz;
    logic [RW-1:0]     rem;
    logic [RW-1:0]     den;
    logic [QW-1:0]     q;
  } psc_tok_t;
endpackage

@@ design/psc_div_cell.sv @@
module psc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  psc_pkg::psc_tok_t  tok_in,
  output psc_pkg::psc_tok_t  tok_out
);
  psc_pkg::psc_tok_t tok_r, tok_nxt;
  logic [psc_pkg::RW-1:0] r2;

  always_comb begin
    tok_nxt = tok_in;
    r2 = {tok_in.rem[psc_pkg::RW-2:0], 1'b0};
    tok_nxt.q = {tok_in.q[psc_pkg::QW-2:0], 1'b0};
    if (r2 >= tok_in.den) begin
      tok_nxt.q[0] = 1'b1;
      tok_nxt.rem = r2 - tok_in.den;
    end else begin
      tok_nxt.rem = r2;
    end
    if (!rst_n) tok_nxt.vld = 1'b0;
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;
endmodule

@@ design/plane_segment_clip_unit.sv @@
// Classifies one segment per clock against the configured plane; each result
// is shown with out_valid high for one cycle. The pipeline holds front-end
// stages, a row of 16 restoring-division cells, one quotient bit per cell, and
// rounding, multiply and output stages. busy is always low: the receiver
// cannot stall and a new segment may start every cycle.
module plane_segment_clip_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_first_x,
  input  logic signed [15:0] in_first_y,
  input  logic signed [15:0] in_first_z,
  input  logic signed [15:0] in_second_x,
  input  logic signed [15:0] in_second_y,
  input  logic signed [15:0] in_second_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_cross_x,
  output logic signed [15:0] out_cross_y,
  output logic signed [15:0] out_cross_z,
  output logic [16:0]        out_cross_param
);
  localparam int CW = psc_pkg::CW;
  localparam int VW = psc_pkg::VW;
  localparam int RW = psc_pkg::RW;
  localparam int NC = psc_pkg::NDIV - 1;

  logic signed [15:0] a_r, b_r, c_r;
  logic signed [31:0] d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= 16'sd256;
      d_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psc_pkg::REG_A: a_r <= cfg_data[15:0];
        psc_pkg::REG_B: b_r <= cfg_data[15:0];
        psc_pkg::REG_C: c_r <= cfg_data[15:0];
        psc_pkg::REG_D: d_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: products
  logic s1_vld_r;
  logic signed [31:0] pa1_r, pb1_r, pc1_r, pa2_r, pb2_r, pc2_r;
  logic signed [CW-1:0] s1_p1x_r, s1_p1y_r, s1_p1z_r;
  logic signed [CW:0] s1_vx_r, s1_vy_r, s1_vz_r;
  logic signed [31:0] s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else s1_vld_r <= start;
    pa1_r <= a_r * in_first_x;
    pb1_r <= b_r * in_first_y;
    pc1_r <= c_r * in_first_z;
    pa2_r <= a_r * in_second_x;
    pb2_r <= b_r * in_second_y;
    pc2_r <= c_r * in_second_z;
    s1_d_r <= d_r;
    s1_p1x_r <= in_first_x;
    s1_p1y_r <= in_first_y;
    s1_p1z_r <= in_first_z;
    s1_vx_r <= 17'(in_second_x) - 17'(in_first_x);
    s1_vy_r <= 17'(in_second_y) - 17'(in_first_y);
    s1_vz_r <= 17'(in_second_z) - 17'(in_first_z);
  end

  // stage 2: plane values
  logic s2_vld_r;
  logic signed [VW-1:0] val1_r, val2_r;
  logic signed [CW-1:0] s2_p1x_r, s2_p1y_r, s2_p1z_r;
  logic signed [CW:0] s2_vx_r, s2_vy_r, s2_vz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else s2_vld_r <= s1_vld_r;
    val1_r <= VW'(pa1_r) + VW'(pb1_r) + VW'(pc1_r) + VW'(s1_d_r);
    val2_r <= VW'(pa2_r) + VW'(pb2_r) + VW'(pc2_r) + VW'(s1_d_r);
    s2_p1x_r <= s1_p1x_r;
    s2_p1y_r <= s1_p1y_r;
    s2_p1z_r <= s1_p1z_r;
    s2_vx_r <= s1_vx_r;
    s2_vy_r <= s1_vy_r;
    s2_vz_r <= s1_vz_r;
  end

  // stage 3: dot = val2 - val1, classification, first quotient bit
  logic signed [VW-1:0] dot;
  logic [VW-1:0] num, den;
  psc_pkg::psc_tok_t tok0_nxt;
  logic [RW-1:0] r0;

  always_comb begin
    dot = val2_r - val1_r;
    num = val1_r[VW-1] ? VW'(-val1_r) : val1_r;
    den = dot[VW-1] ? VW'(-dot) : dot;
    tok0_nxt = '0;
    tok0_nxt.vld = s2_vld_r && rst_n;
    tok0_nxt.neg2 = val2_r[VW-1];
    tok0_nxt.p1x = s2_p1x_r;
    tok0_nxt.p1y = s2_p1y_r;
    tok0_nxt.p1z = s2_p1z_r;
    tok0_nxt.vx = s2_vx_r;
    tok0_nxt.vy = s2_vy_r;
    tok0_nxt.vz = s2_vz_r;
    tok0_nxt.den = RW'(den);
    r0 = RW'(num);
    tok0_nxt.status = psc_pkg::ST_OUT;
    tok0_nxt.go = 1'b0;
    if (!val1_r[VW-1] && val1_r != 0 && !val2_r[VW-1] && val2_r != 0) begin
      tok0_nxt.status = psc_pkg::ST_OUT;
    end else if ((val1_r == 0 && val2_r == 0) || (val1_r[VW-1] && val2_r[VW-1])) begin
      tok0_nxt.status = psc_pkg::ST_SAME;
    end else if (dot == 0) begin
      tok0_nxt.status = psc_pkg::ST_OUT;
    end else if (den <= (num >> psc_pkg::TOL_SHIFT)) begin
      tok0_nxt.status = psc_pkg::ST_OUT;
    end else if (val1_r != 0 && (val1_r[VW-1] == dot[VW-1])) begin
      tok0_nxt.status = psc_pkg::ST_OUT;
    end else if (num > den) begin
      tok0_nxt.status = psc_pkg::ST_OUT;
    end else begin
      tok0_nxt.go = 1'b1;
      tok0_nxt.status = val2_r[VW-1] ? psc_pkg::ST_CROSS_NEG : psc_pkg::ST_CROSS;
    end
    if (r0 >= RW'(den)) begin
      tok0_nxt.q = psc_pkg::QW'(1);
      tok0_nxt.rem = r0 - RW'(den);
    end else begin
      tok0_nxt.rem = r0;
    end
  end

  psc_pkg::psc_tok_t tok_r;
  always_ff @(posedge clk) begin
    tok_r <= tok0_nxt;
  end

  psc_pkg::psc_tok_t chain [NC+1];
  assign chain[0] = tok_r;
  for (genvar g = 0; g < NC; g++) begin : g_cell
    psc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  // rounding stage
  psc_pkg::psc_tok_t tl;
  logic [16:0] q_nxt;
  logic t_vld_r, t_go_r;
  logic [1:0] t_st_r;
  logic [16:0] t_q_r;
  logic signed [CW-1:0] t_p1x_r, t_p1y_r, t_p1z_r;
  logic signed [CW:0] t_vx_r, t_vy_r, t_vz_r;

  always_comb begin
    tl = chain[NC];
    q_nxt = ({tl.rem[RW-2:0], 1'b0} >= tl.den) ? tl.q + 17'd1 : tl.q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) t_vld_r <= 1'b0;
    else t_vld_r <= tl.vld;
    t_go_r <= tl.go;
    t_st_r <= tl.status;
    t_q_r <= q_nxt;
    t_p1x_r <= tl.p1x;
    t_p1y_r <= tl.p1y;
    t_p1z_r <= tl.p1z;
    t_vx_r <= tl.vx;
    t_vy_r <= tl.vy;
    t_vz_r <= tl.vz;
  end

  // multiply stage
  logic m_vld_r, m_go_r;
  logic [1:0] m_st_r;
  logic [16:0] m_q_r;
  logic signed [CW-1:0] m_p1x_r, m_p1y_r, m_p1z_r;
  logic signed [35:0] mx_r, my_r, mz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else m_vld_r <= t_vld_r;
    m_go_r <= t_go_r;
    m_st_r <= t_st_r;
    m_q_r <= t_q_r;
    m_p1x_r <= t_p1x_r;
    m_p1y_r <= t_p1y_r;
    m_p1z_r <= t_p1z_r;
    mx_r <= 36'($signed({1'b0, t_q_r}) * t_vx_r) + 36'sd32768;
    my_r <= 36'($signed({1'b0, t_q_r}) * t_vy_r) + 36'sd32768;
    mz_r <= 36'($signed({1'b0, t_q_r}) * t_vz_r) + 36'sd32768;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= m_vld_r;
    out_status <= m_st_r;
    if (m_go_r) begin
      out_cross_x <= m_p1x_r + CW'(mx_r >>> 16);
      out_cross_y <= m_p1y_r + CW'(my_r >>> 16);
      out_cross_z <= m_p1z_r + CW'(mz_r >>> 16);
      out_cross_param <= m_q_r;
    end else begin
      out_cross_x <= '0;
      out_cross_y <= '0;
      out_cross_z <= '0;
      out_cross_param <= '0;
    end
  end

`ifndef SYNTHESIS
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cross_param <= 17'd65536)
    else $error("crossing parameter above one");
  a_zero_nocross: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == psc_pkg::ST_OUT || out_status == psc_pkg::ST_SAME))
      |-> (out_cross_param == '0 && out_cross_x == '0))
    else $error("non-crossing result carries a point");
  a_cross_status: assert property (@(posedge clk) disable iff (!rst_n)
    m_vld_r && m_go_r |=> out_status[1])
    else $error("crossing without crossing status");
`endif
endmodule
